/* rtl/assert_macros.svh */
// Assertion macros used by the checker of the sorted priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on the rising edge and disabled while reset is low.
`define SPQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Types and codes shared by the sorted priority queue modules.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int KEY_W  = 16;
  localparam int PRIO_W = 4;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHANGE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_LIST      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

/* rtl/spq_cell.sv */
// One cell of the sorted chain: holds a single entry and trades it with its neighbours.
`timescale 1ns / 1ps
module spq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spq_pkg::cmd_t   cmd_i,
  input  spq_pkg::entry_t prev_i,
  input  spq_pkg::entry_t next_i,
  input  spq_pkg::entry_t head_i,
  input  logic            after_i,
  input  logic            seen_i,
  output spq_pkg::entry_t cell_o,
  output logic            after_o,
  output logic            seen_o
);
  import spq_pkg::*;

  logic              valid_q, valid_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [PRIO_W-1:0] prio_q, prio_d;

  assign cell_o  = '{valid: valid_q, key: key_q, prio: prio_q};
  // The new entry belongs behind this cell when this one holds an equal or smaller priority.
  assign after_o = valid_q && (prio_q <= cmd_i.prio);
  // Set from the first matching cell onwards, so every cell from there on closes the gap.
  assign seen_o  = seen_i || (valid_q && (key_q == cmd_i.key));

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    prio_d  = prio_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (!after_o) begin
          if (after_i) begin
            valid_d = 1'b1;
            key_d   = cmd_i.key;
            prio_d  = cmd_i.prio;
          end else begin
            valid_d = prev_i.valid;
            key_d   = prev_i.key;
            prio_d  = prev_i.prio;
          end
        end
      end
      OP_REMOVE: begin
        if (seen_o) begin
          valid_d = next_i.valid;
          key_d   = next_i.key;
          prio_d  = next_i.prio;
        end
      end
      OP_ROTATE: begin
        if (valid_q) begin
          if (next_i.valid) begin
            key_d  = next_i.key;
            prio_d = next_i.prio;
          end else begin
            key_d  = head_i.key;
            prio_d = head_i.prio;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prio_q <= prio_d;
  end

endmodule

/* rtl/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue: cell chain, request sequencer and result register.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake            | Beat contents
//  --------+-----------+----------------------+---------------------------------------------
//  in      | to core   | in_valid_i/in_stall_o | req_type_i, entry_key_i, entry_priority_i
//  out     | from core | out_valid_o/out_stall_i | status_o, out_key_o, out_priority_o,
//          |           |                      | occupancy_o, last_o
//
//  Insert and remove: the whole chain shifts in the cycle the beat is taken.
//  Change priority is a remove followed, in the next cycle, by an insert of the same key.
//  A list request shows the stored entries in order on the output, one beat each, set
//  by the rotation of the chain through its head cell; on an empty queue it gives one beat.
//  Reset empties the queue at once; no clearing pass is needed.
//  A stalled output holds its beat and stalls the input, and also pauses a running list; the
//  next request is taken no earlier than the cycle in which the held beat leaves.
//
// The queue is a row of CAPACITY cells, each holding one entry, kept sorted by ascending
// priority from the head (cell 0). Every cell compares its own entry against the broadcast
// request and decides locally whether to keep its entry, take the neighbour's one or take
// the new entry, so insert and remove complete without a shared shifter.
// Listing rotates the chain by one place a cycle while the output is not stalled: the head
// entry is shown on the output and is written back into the last occupied cell, so after as
// many steps as there are entries the original order is restored.
module sorted_priority_queue_core #(
  parameter int CAPACITY = 16,
  localparam int CntW    = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [spq_pkg::REQ_W-1:0]   req_type_i,
  input  logic [spq_pkg::KEY_W-1:0]   entry_key_i,
  input  logic [spq_pkg::PRIO_W-1:0]  entry_priority_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [spq_pkg::STAT_W-1:0]  status_o,
  output logic [spq_pkg::KEY_W-1:0]   out_key_o,
  output logic [spq_pkg::PRIO_W-1:0]  out_priority_o,
  output logic [CntW-1:0]             occupancy_o,
  output logic                        last_o
);
  import spq_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_LIST = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   remain_q, remain_d;
  logic [KEY_W-1:0]  pend_key_q;
  logic [PRIO_W-1:0] pend_prio_q;

  // Result register.
  logic              out_valid_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic [KEY_W-1:0]  okey_q, okey_d;
  logic [PRIO_W-1:0] oprio_q, oprio_d;
  logic [CntW-1:0]   occ_q, occ_d;
  logic              last_q, last_d;
  logic              load_out;

  cmd_t   cmd;
  entry_t cells  [CAPACITY];
  logic   after_w[CAPACITY];
  logic   seen_w [CAPACITY];

  logic accept;
  logic out_free;
  logic full;
  logic found;

  // The result register may take a new beat when it is empty or is being drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(CAPACITY));
  // The match flag ripples from head to tail; it leaves the last cell set if any cell matched.
  assign found      = seen_w[CAPACITY-1];

  // Cell chain. Cell 0 treats the space before it as holding a smaller priority, and the
  // space behind the last cell reads as an empty entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_w;
    entry_t next_w;
    logic   after_in;
    logic   seen_in;

    if (i == 0) begin : g_head
      assign prev_w   = '0;
      assign after_in = 1'b1;
      assign seen_in  = 1'b0;
    end else begin : g_body
      assign prev_w   = cells[i-1];
      assign after_in = after_w[i-1];
      assign seen_in  = seen_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = cells[i+1];
    end

    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .head_i  (cells[0]),
      .after_i (after_in),
      .seen_i  (seen_in),
      .cell_o  (cells[i]),
      .after_o (after_w[i]),
      .seen_o  (seen_w[i])
    );
  end

  // Request sequencer. Change priority reports its result as soon as the remove has found
  // the key: the count is the same after the re-insert, which follows in the next cycle.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    remain_d = remain_q;
    cmd      = '{op: OP_NOP, key: entry_key_i, prio: entry_priority_i};
    load_out = 1'b0;
    status_d = STAT_DONE;
    okey_d   = '0;
    oprio_d  = '0;
    occ_d    = count_q;
    last_d   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_INSERT: begin
              load_out = 1'b1;
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                cmd.op   = OP_INSERT;
                count_d  = count_q + CntW'(1);
                status_d = STAT_DONE;
              end
              occ_d = count_d;
            end
            REQ_REMOVE: begin
              load_out = 1'b1;
              cmd.op   = OP_REMOVE;
              if (found) begin
                count_d  = count_q - CntW'(1);
                status_d = STAT_DONE;
              end else begin
                status_d = STAT_NOT_FOUND;
              end
              occ_d = count_d;
            end
            REQ_CHANGE: begin
              load_out = 1'b1;
              cmd.op   = OP_REMOVE;
              if (found) begin
                status_d = STAT_DONE;
                state_d  = S_INS;
              end else begin
                status_d = STAT_NOT_FOUND;
              end
            end
            REQ_LIST: begin
              if (count_q == '0) begin
                load_out = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                remain_d = count_q;
                state_d  = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        cmd     = '{op: OP_INSERT, key: pend_key_q, prio: pend_prio_q};
        state_d = S_IDLE;
      end
      S_LIST: begin
        if (out_free) begin
          cmd.op   = OP_ROTATE;
          load_out = 1'b1;
          status_d = STAT_LIST;
          okey_d   = cells[0].key;
          oprio_d  = cells[0].prio;
          last_d   = (remain_q == CntW'(1));
          remain_d = remain_q - CntW'(1);
          if (remain_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_key_q  <= entry_key_i;
      pend_prio_q <= entry_priority_i;
    end
    if (load_out) begin
      status_q <= status_d;
      okey_q   <= okey_d;
      oprio_q  <= oprio_d;
      occ_q    <= occ_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_key_o      = okey_q;
  assign out_priority_o = oprio_q;
  assign occupancy_o    = occ_q;
  assign last_o         = last_q;

endmodule

/* rtl/spq_checker.sv */
// Port-level checker for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spq_checker #(
  parameter int CAPACITY = 16,
  localparam int CntW    = $clog2(CAPACITY + 1)
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [spq_pkg::STAT_W-1:0] status_o,
  input logic [spq_pkg::KEY_W-1:0]  out_key_o,
  input logic [spq_pkg::PRIO_W-1:0] out_priority_o,
  input logic [CntW-1:0]            occupancy_o,
  input logic                       last_o
);
  import spq_pkg::*;

  logic list_beat;
  assign list_beat = out_valid_o && (status_o == STAT_LIST);

  `SPQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result beat dropped while stalled")
  `SPQ_ASSERT(a_occ_range, clk_i, rst_ni, out_valid_o |-> occupancy_o <= CntW'(CAPACITY), "occupancy beyond capacity")
  `SPQ_ASSERT(a_empty_list, clk_i, rst_ni, out_valid_o && (status_o == STAT_EMPTY) |-> (occupancy_o == '0) && last_o, "empty list beat malformed")
  `SPQ_ASSERT(a_single_beat, clk_i, rst_ni, out_valid_o && !list_beat |-> last_o && (out_key_o == '0) && (out_priority_o == '0), "single result beat malformed")
  `SPQ_ASSERT(a_list_occ, clk_i, rst_ni, list_beat |-> occupancy_o != '0, "list entry reported with empty queue")

endmodule

bind sorted_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .out_key_o      (out_key_o),
  .out_priority_o (out_priority_o),
  .occupancy_o    (occupancy_o),
  .last_o         (last_o)
);

/* dv/tb_sorted_priority_queue_core.sv */
// Self-checking testbench for the sorted priority queue core, driven by random and directed requests.
`timescale 1ns / 1ps
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int CAP    = 16;
  localparam int OCC_W  = $clog2(CAP + 1);
  localparam int IDLE_PCT = 37;

  // One request beat as the sender will drive it.
  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } request_t;

  // One result beat as the core should produce it.
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occ;
    logic              last;
  } result_t;

  // One entry of the shadow copy of the queue.
  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [REQ_W-1:0]  req_type_i       = REQ_INSERT;
  logic [KEY_W-1:0]  entry_key_i      = '0;
  logic [PRIO_W-1:0] entry_priority_i = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b1;
  logic [STAT_W-1:0] status_o;
  logic [KEY_W-1:0]  out_key_o;
  logic [PRIO_W-1:0] out_priority_o;
  logic [OCC_W-1:0]  occupancy_o;
  logic              last_o;

  request_t request_queue[$];
  result_t  pending_results[$];
  slot_t    shadow_queue[$];
  int       requests_taken = 0;
  int       error_count    = 0;
  logic [KEY_W-1:0] key_pool[6];

  sorted_priority_queue_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .entry_key_i     (entry_key_i),
    .entry_priority_i(entry_priority_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .out_key_o       (out_key_o),
    .out_priority_o  (out_priority_o),
    .occupancy_o     (occupancy_o),
    .last_o          (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Between the 60th and the 110th request neither side idles, so the core also sees a
  // long stretch of back-to-back beats on both channels.
  wire calm = (requests_taken >= 60) && (requests_taken < 110);

  function automatic result_t make_result(logic [STAT_W-1:0] status, logic [KEY_W-1:0] key,
                                          logic [PRIO_W-1:0] prio, logic last);
    result_t r;
    r.status = status;
    r.key    = key;
    r.prio   = prio;
    r.occ    = OCC_W'(shadow_queue.size());
    r.last   = last;
    return r;
  endfunction

  // A new entry goes behind every entry whose priority is not larger than its own.
  function automatic bit shadow_insert(logic [KEY_W-1:0] key, logic [PRIO_W-1:0] prio);
    slot_t s;
    int    pos;
    if (shadow_queue.size() >= CAP) return 1'b0;
    pos = 0;
    while (pos < shadow_queue.size() && prio >= shadow_queue[pos].prio) pos++;
    s.key  = key;
    s.prio = prio;
    shadow_queue.insert(pos, s);
    return 1'b1;
  endfunction

  // Only the match nearest the head is taken out.
  function automatic bit shadow_remove(logic [KEY_W-1:0] key);
    for (int i = 0; i < shadow_queue.size(); i++) begin
      if (shadow_queue[i].key == key) begin
        shadow_queue.delete(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Updates the shadow queue for one accepted request and queues the result beats it causes.
  task automatic apply_request(request_t rq);
    bit ok;
    case (rq.req)
      REQ_INSERT: begin
        ok = shadow_insert(rq.key, rq.prio);
        pending_results.push_back(make_result(ok ? STAT_DONE : STAT_FULL, '0, '0, 1'b1));
      end
      REQ_REMOVE: begin
        ok = shadow_remove(rq.key);
        pending_results.push_back(make_result(ok ? STAT_DONE : STAT_NOT_FOUND, '0, '0, 1'b1));
      end
      REQ_CHANGE: begin
        ok = shadow_remove(rq.key);
        if (ok) ok = shadow_insert(rq.key, rq.prio);
        pending_results.push_back(make_result(ok ? STAT_DONE : STAT_NOT_FOUND, '0, '0, 1'b1));
      end
      default: begin
        if (shadow_queue.size() == 0) begin
          pending_results.push_back(make_result(STAT_EMPTY, '0, '0, 1'b1));
        end else begin
          foreach (shadow_queue[i]) begin
            pending_results.push_back(make_result(STAT_LIST, shadow_queue[i].key,
                shadow_queue[i].prio, i == shadow_queue.size() - 1));
          end
        end
      end
    endcase
  endtask

  // Request driver: the beat on the bus is taken when valid is high and stall is low, and
  // only then may the next beat from the request queue replace it.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t rq;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rq.req  = req_type_i;
        rq.key  = entry_key_i;
        rq.prio = entry_priority_i;
        apply_request(rq);
        requests_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          rq = request_queue.pop_front();
          in_valid_i       <= 1'b1;
          req_type_i       <= rq.req;
          entry_key_i      <= rq.key;
          entry_priority_i <= rq.prio;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every taken result beat is compared field by field with the oldest
  // prediction. The stall input is redrawn on every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: status %0d key %h", status_o, out_key_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
          if (out_key_o !== want.key) begin
            $error("out_key: expected %h, got %h", want.key, out_key_o);
            error_count++;
          end
          if (out_priority_o !== want.prio) begin
            $error("out_priority: expected %0d, got %0d", want.prio, out_priority_o);
            error_count++;
          end
          if (occupancy_o !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy_o);
            error_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            error_count++;
          end
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic queue_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                               logic [PRIO_W-1:0] prio);
    request_t rq;
    rq.req  = req;
    rq.key  = key;
    rq.prio = prio;
    request_queue.push_back(rq);
  endtask

  initial begin
    int unsigned pick;
    bit          filling;
    logic [KEY_W-1:0] key;

    // Directed opening: every request on an empty queue, then a fill to capacity with the
    // extreme keys and priorities, duplicate keys and ties, an insert into a full queue,
    // a change of priority while full and a remove that must hit the match nearest the head.
    queue_request(REQ_LIST, '0, '0);
    queue_request(REQ_REMOVE, 16'h1234, '0);
    queue_request(REQ_CHANGE, 16'h1234, 4'd5);
    queue_request(REQ_INSERT, 16'h0000, 4'd0);
    queue_request(REQ_INSERT, 16'hFFFF, 4'd15);
    queue_request(REQ_INSERT, 16'h1234, 4'd7);
    queue_request(REQ_INSERT, 16'h1234, 4'd7);
    queue_request(REQ_INSERT, 16'hA5A5, 4'd7);
    queue_request(REQ_INSERT, 16'h5A5A, 4'd3);
    queue_request(REQ_INSERT, 16'h1234, 4'd2);
    for (int i = 0; i < 9; i++) begin
      queue_request(REQ_INSERT, KEY_W'(16'h0100 + i), PRIO_W'((i * 5) % 16));
    end
    queue_request(REQ_INSERT, 16'hBEEF, 4'd0);
    queue_request(REQ_CHANGE, 16'h1234, 4'd15);
    queue_request(REQ_REMOVE, 16'h1234, '0);
    queue_request(REQ_LIST, '0, '0);

    // Random part: a small pool of keys makes hits and duplicates common. Each burst is drawn
    // at random as filling or draining, so that both the full and the empty queue can be reached.
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 65535));
    filling = 1'b1;
    for (int n = 0; n < 147; n++) begin
      if (n % 20 == 0) filling = 1'($urandom_range(1));
      key  = ($urandom_range(99) < 80) ? key_pool[3'($urandom_range(5))]
                                        : KEY_W'($urandom_range(0, 65535));
      pick = $urandom_range(99);
      if (filling) begin
        if (pick < 60)      queue_request(REQ_INSERT, key, PRIO_W'($urandom_range(15)));
        else if (pick < 75) queue_request(REQ_REMOVE, key, PRIO_W'($urandom_range(15)));
        else if (pick < 90) queue_request(REQ_CHANGE, key, PRIO_W'($urandom_range(15)));
        else                queue_request(REQ_LIST, key, PRIO_W'($urandom_range(15)));
      end else begin
        if (pick < 20)      queue_request(REQ_INSERT, key, PRIO_W'($urandom_range(15)));
        else if (pick < 65) queue_request(REQ_REMOVE, key, PRIO_W'($urandom_range(15)));
        else if (pick < 85) queue_request(REQ_CHANGE, key, PRIO_W'($urandom_range(15)));
        else                queue_request(REQ_LIST, key, PRIO_W'($urandom_range(15)));
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (request_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    // A list beat may still be in flight behind the final one; give the core time to
    // show any stray beat before the verdict.
    repeat (4 * CAP) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
